FILE: hw/rtl/wft_pkg.sv
// Shared types and constants for the Wiegand frame transmitter.
// No dependencies; imported by every module of the block.
package wft_pkg;

    localparam int BIT_COUNT_CAP = 64;
    localparam int DATA_W       = 64;
    localparam int FRAME_W      = DATA_W + 2;
    localparam int COUNT_W      = 7;
    localparam int PULSE_W      = 16;
    localparam int GAP_W        = 20;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 8;

    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd1;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 20'd18;

    // register indexes on the write port
    localparam logic REG_PULSE = 1'b0;
    localparam logic REG_GAP   = 1'b1;

    // request kinds carried in tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_GAP   = 2'd2
    } t_phase;

    // one queued request, already turned into line bits by the front
    typedef struct packed {
        logic                op;
        logic [FRAME_W-1:0]  frame;
        logic [COUNT_W-1:0]  count;
    } t_entry;

    // result flags, packed lowest bit first into the output tdata
    typedef struct packed {
        logic rej;
        logic done;
        logic busy;
        logic d1;
        logic d0;
    } t_result;

endpackage

FILE: hw/rtl/wft_front.sv
// Front end: unpacks a request and, for a start, builds the line bit sequence
// with parity. Depends on wft_pkg.
module wft_front (
    input  logic [wft_pkg::S_TDATA_W-1:0] i_tdata,  // frame_data, bit_count, msb_first, parity_enable
    input  logic                          i_tuser,  // op
    output wft_pkg::t_entry               o_entry
);
    import wft_pkg::*;

    function automatic logic [DATA_W-1:0] low_mask(input logic [COUNT_W-1:0] w);
        logic [DATA_W-1:0] m;
        if (w >= COUNT_W'(DATA_W)) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << w) - DATA_W'(1);
        end
        return m;
    endfunction

    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] raw_n;
    logic               msb;
    logic               par;
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] h;
    logic [DATA_W-1:0]  m_n;
    logic [DATA_W-1:0]  m_h;
    logic [DATA_W-1:0]  m_nh;
    logic               p_low;
    logic               p_high;
    logic               lead;
    logic               trail;
    logic [DATA_W-1:0]  rev;
    logic [DATA_W-1:0]  sent;
    logic [FRAME_W-1:0] frame;

    assign data  = i_tdata[DATA_W-1:0];
    assign raw_n = i_tdata[DATA_W+COUNT_W-1:DATA_W];
    assign msb   = i_tdata[DATA_W+COUNT_W];
    assign par   = i_tdata[DATA_W+COUNT_W+1];

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            rev[i] = data[DATA_W-1-i];
        end
    end

    always_comb begin
        n      = (raw_n > COUNT_W'(BIT_COUNT_CAP)) ? COUNT_W'(BIT_COUNT_CAP) : raw_n;
        h      = COUNT_W'((8'(n) + 8'd1) >> 1);
        m_n    = low_mask(n);
        m_h    = low_mask(h);
        m_nh   = low_mask(n - h);
        // parity over the low half and the high half of the n data bits that are sent
        p_low  = ^(data & m_h);
        p_high = ^(data & m_n & ~m_nh);
        if (msb) begin
            lead  = p_high;
            trail = ~p_low;
            sent  = rev >> (COUNT_W'(DATA_W) - n);
        end else begin
            lead  = ~p_low;
            trail = p_high;
            sent  = data & m_n;
        end
        if (par) begin
            frame = ({2'b00, sent} << 1) | FRAME_W'(lead)
                  | (FRAME_W'(trail) << (n + COUNT_W'(1)));
        end else begin
            frame = {2'b00, sent};
        end
        o_entry.op    = i_tuser;
        o_entry.frame = frame;
        o_entry.count = n + (par ? COUNT_W'(2) : COUNT_W'(0));
    end

endmodule

FILE: hw/rtl/wft_fifo.sv
// Two-entry request queue between front and back.
// Depends on wft_pkg for the entry type.
module wft_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wft_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output wft_pkg::t_entry o_entry
);
    import wft_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr)) else $error("queue pointers inconsistent");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue count slip on pop");
`endif

endmodule

FILE: hw/rtl/wft_back.sv
// Back end: line sequencer (pulse/gap timing, frame shift-out), timing
// registers and the output register. Depends on wft_pkg.
module wft_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [wft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_empty,
    input  wft_pkg::t_entry                i_entry,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [wft_pkg::M_TDATA_W-1:0]  o_m_tdata   // data0, data1, busy, done, rejected
);
    import wft_pkg::*;

    logic [PULSE_W-1:0] r_pulse;
    logic [GAP_W-1:0]   r_gap;
    logic [FRAME_W-1:0] r_frame;
    logic [COUNT_W-1:0] r_rem;
    t_phase             r_phase;
    logic [GAP_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_result            r_out;

    t_phase             n_phase;
    logic [FRAME_W-1:0] n_frame;
    logic [COUNT_W-1:0] n_rem;
    logic [GAP_W-1:0]   n_cnt;
    t_result            n_out;

    logic               active;
    logic [GAP_W-1:0]   cnt_inc;
    logic [GAP_W-1:0]   pulse_lim;
    logic [GAP_W-1:0]   gap_lim;
    logic [COUNT_W-1:0] rem_dec;
    logic               pulse_end;
    logic               gap_end;

    assign o_pop      = !i_empty && (!r_out_valid || i_m_tready);
    assign active     = (r_phase == PH_PULSE) || (r_phase == PH_GAP);
    assign cnt_inc    = r_cnt + GAP_W'(1);
    assign pulse_lim  = (r_pulse == '0) ? GAP_W'(1) : GAP_W'(r_pulse);
    assign gap_lim    = (r_gap == '0) ? GAP_W'(1) : r_gap;
    assign rem_dec    = (r_rem != '0) ? r_rem - COUNT_W'(1) : r_rem;
    assign pulse_end  = (cnt_inc >= pulse_lim);
    assign gap_end    = (cnt_inc >= gap_lim);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            if (i_entry.op == OP_START) begin
                if (!active) begin
                    n_phase = (i_entry.count == '0) ? PH_IDLE : PH_PULSE;
                end
            end else begin
                case (r_phase)
                    PH_PULSE: begin
                        if (pulse_end) n_phase = PH_GAP;
                    end
                    PH_GAP: begin
                        if (gap_end) n_phase = (rem_dec == '0) ? PH_IDLE : PH_PULSE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_frame    = r_frame;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_out.d0   = !((r_phase == PH_PULSE) && !r_frame[0]);
        n_out.d1   = !((r_phase == PH_PULSE) && r_frame[0]);
        n_out.done = 1'b0;
        n_out.rej  = 1'b0;
        n_out.busy = (n_phase == PH_PULSE) || (n_phase == PH_GAP);
        if (i_entry.op == OP_START) begin
            if (active) begin
                n_out.rej = 1'b1;
            end else begin
                n_frame    = i_entry.frame;
                n_rem      = i_entry.count;
                n_cnt      = '0;
                n_out.done = (i_entry.count == '0);
            end
        end else begin
            case (r_phase)
                PH_PULSE: begin
                    n_cnt = pulse_end ? '0 : cnt_inc;
                end
                PH_GAP: begin
                    if (gap_end) begin
                        n_cnt      = '0;
                        n_frame    = r_frame >> 1;
                        n_rem      = rem_dec;
                        n_out.done = (rem_dec == '0);
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: n_cnt = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse     <= PULSE_RESET;
            r_gap       <= GAP_RESET;
            r_frame     <= '0;
            r_rem       <= '0;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PULSE: r_pulse <= i_cfg_data[PULSE_W-1:0];
                    REG_GAP:   r_gap   <= i_cfg_data[GAP_W-1:0];
                    default:   r_gap   <= r_gap;
                endcase
            end
            if (o_pop) begin
                r_frame     <= n_frame;
                r_rem       <= n_rem;
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done |-> !r_out.busy) else $error("done while busy");
    a_lines_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.d0 || r_out.d1)) else $error("both lines low");
    a_busy_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        active |-> (r_rem != '0)) else $error("active with no bits left");
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !active |-> (r_cnt == '0)) else $error("phase counter running while idle");
`endif

endmodule

FILE: hw/rtl/wiegand_frame_transmitter_top.sv
// Top level of the Wiegand frame transmitter: front end, request queue, back end.
// Depends on wft_pkg, wft_front, wft_fifo and wft_back.
//
// Channel   Dir  Handshake              Payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata: frame_data, bit_count, msb_first, parity_enable
//                                       tuser: op (0 tick, 1 start)
// m (out)   out  o_m_tvalid/i_m_tready  tdata: data0, data1, busy, done, rejected
// cfg       in   i_cfg_we               i_cfg_idx: 0 pulse_ticks, 1 gap_ticks; i_cfg_data
//
// One request per clock sustained while the output is not stalled; each passes the queue, then the output register.
// The front builds the parity-framed bit sequence in the accepting cycle; the back
// sequencer (pulse/gap counter and shift-out) handles one queued request a cycle unless the output stalls.
// Reset is synchronous, active low: idle, lines high, timing registers to 1 and 18.
// A stalled output holds its result; the two-entry queue takes one more request,
// then o_s_tready drops until the output drains.
module wiegand_frame_transmitter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [wft_pkg::S_TDATA_W-1:0]  i_s_tdata,  // frame_data, bit_count, msb_first, parity_enable, zero pad
    input  logic                           i_s_tuser,  // op
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [wft_pkg::M_TDATA_W-1:0]  o_m_tdata,  // data0, data1, busy, done, rejected, zero pad
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [wft_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wft_pkg::*;

    t_entry front_entry;
    t_entry queue_entry;
    logic   queue_full;
    logic   queue_empty;
    logic   queue_pop;

    // classify and pre-frame the request
    wft_front u_front (
        .i_tdata (i_s_tdata),
        .i_tuser (i_s_tuser),
        .o_entry (front_entry)
    );

    assign o_s_tready = !queue_full;

    // decouples acceptance from output back-pressure
    wft_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_entry (queue_entry)
    );

    // line sequencer and output register
    wft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (queue_empty),
        .i_entry    (queue_entry),
        .o_pop      (queue_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: tb/tb_wiegand_frame_transmitter_top.sv
// Self-checking testbench for wiegand_frame_transmitter_top: tick and start requests
// go in, the line levels and flags of every result are predicted and compared.
// Depends on wft_pkg and the transmitter RTL; no files, no arguments.
module tb_wiegand_frame_transmitter_top;
    import wft_pkg::*;

    // Watchdog limit, far above the length of the slowest run.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Long receiver hold, well past the two-entry queue plus pipeline.
    localparam int unsigned HOLD_CYCLES   = 60;
    // Settling time after the last result before touching the timing registers.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RESET_CYCLES  = 12;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we   = 1'b0;
    logic                  cfg_idx  = REG_PULSE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted transmitter state: timing, shift register, phase and tick counter.
    logic [PULSE_W-1:0]    pulse_len;
    logic [GAP_W-1:0]      gap_len;
    logic [FRAME_W-1:0]    line_bits;
    logic [COUNT_W-1:0]    bits_left;
    t_phase                tx_phase;
    logic [GAP_W-1:0]      tick_count;

    // Line levels and flags still owed by the block, oldest first.
    t_result               expected_levels[$];

    int unsigned           mismatches    = 0;
    int unsigned           results_seen  = 0;
    int unsigned           requests_sent = 0;
    int unsigned           cycles        = 0;

    // Random idling on both sides; switched off for the last stretch.
    logic                  idling_on = 1'b1;
    // Bumped by a test to ask the receiver for one long hold.
    int unsigned           hold_asks = 0;

    // Receiver-side idling state, owned by the receiver process.
    int unsigned           hold_left  = 0;
    int unsigned           hold_seen  = 0;
    int unsigned           stall_left = 0;

    wiegand_frame_transmitter_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),  // frame_data, bit_count, msb_first, parity_enable, zero pad
        .i_s_tuser  (s_tuser),  // op
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),  // data0, data1, busy, done, rejected, zero pad
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic reset_wiegand_state();
        pulse_len  = PULSE_RESET;
        gap_len    = GAP_RESET;
        line_bits  = '0;
        bits_left  = '0;
        tx_phase   = PH_IDLE;
        tick_count = '0;
    endtask

    // Levels held during one request, then the state moved on by it.
    function automatic t_result wiegand_step(input logic op, input logic [DATA_W-1:0] data,
                                             input logic [COUNT_W-1:0] cnt, input logic msb,
                                             input logic par);
        t_result          r;
        logic             active;
        logic             lead;
        logic             trail;
        logic             b;
        logic [GAP_W-1:0] lim;
        int               n;
        int               h;
        int               pos;
        r      = '0;
        r.d0   = 1'b1;
        r.d1   = 1'b1;
        active = (tx_phase == PH_PULSE) || (tx_phase == PH_GAP);
        // lines show the bit at the head of the shift register while pulsing
        if (tx_phase == PH_PULSE) begin
            if (line_bits[0]) r.d1 = 1'b0;
            else r.d0 = 1'b0;
        end
        if (op == OP_START) begin
            if (active) begin
                r.rej = 1'b1;
            end else begin
                n     = (cnt > BIT_COUNT_CAP) ? BIT_COUNT_CAP : int'(cnt);
                h     = (n + 1) / 2;
                // msb order: even leading, odd trailing; lsb order the other way round
                lead  = ~msb;
                trail = msb;
                line_bits = '0;
                pos   = par ? 1 : 0;
                for (int k = 0; k < n; k++) begin
                    b = msb ? data[n - 1 - k] : data[k];
                    if (k < h) lead ^= b;
                    if (k >= n - h) trail ^= b;
                    line_bits[pos] = b;
                    pos++;
                end
                if (par) begin
                    line_bits[0]   = lead;
                    line_bits[pos] = trail;
                    pos++;
                end
                bits_left  = pos[COUNT_W-1:0];
                tick_count = '0;
                if (pos == 0) begin
                    tx_phase = PH_IDLE;
                    r.done   = 1'b1;
                end else begin
                    tx_phase = PH_PULSE;
                end
            end
        end else if (tx_phase == PH_PULSE) begin
            lim = (pulse_len == '0) ? GAP_W'(1) : GAP_W'(pulse_len);
            tick_count++;
            if (tick_count >= lim) begin
                tx_phase   = PH_GAP;
                tick_count = '0;
            end
        end else if (tx_phase == PH_GAP) begin
            lim = (gap_len == '0) ? GAP_W'(1) : gap_len;
            tick_count++;
            if (tick_count >= lim) begin
                tick_count = '0;
                line_bits  = line_bits >> 1;
                if (bits_left != '0) bits_left--;
                if (bits_left == '0) begin
                    tx_phase = PH_IDLE;
                    r.done   = 1'b1;
                end else begin
                    tx_phase = PH_PULSE;
                end
            end
        end else begin
            tx_phase   = PH_IDLE;
            tick_count = '0;
        end
        r.busy = (tx_phase == PH_PULSE) || (tx_phase == PH_GAP);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // One request. tvalid is left high on return so that a following request
    // can go back to back; anything else lowers it first.
    task automatic send_request(input logic op, input logic [DATA_W-1:0] data,
                                input logic [COUNT_W-1:0] cnt, input logic msb,
                                input logic par);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({par, msb, cnt, data});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_levels.push_back(wiegand_step(op, data, cnt, msb, par));
        requests_sent++;
    endtask

    // Tick with junk in the unused fields.
    task automatic send_tick();
        send_request(OP_TICK, {$urandom, $urandom}, COUNT_W'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Bit counts mostly short so frames finish; some longer up to full length, some oversized.
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return COUNT_W'($urandom_range(0, 20));
        if (r < 95) return COUNT_W'($urandom_range(21, 64));
        return COUNT_W'($urandom_range(65, 127));
    endfunction

    task automatic send_random_start();
        send_request(OP_START, {$urandom, $urandom}, pick_count(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Tick until the frame is out, with the odd start while busy thrown in.
    task automatic run_out_frame(input int unsigned reject_pct);
        while (tx_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < reject_pct) send_random_start();
            else send_tick();
        end
    endtask

    task automatic send_frame(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] cnt,
                              input logic msb, input logic par, input int unsigned reject_pct);
        send_request(OP_START, data, cnt, msb, par);
        run_out_frame(reject_pct);
    endtask

    // Stop offering, let every owed result arrive, then let the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Timing register write, only ever with the block quiet.
    task automatic write_timing(input logic idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_PULSE) pulse_len = value[PULSE_W-1:0];
        else gap_len = value[GAP_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver: one long hold when asked, else short random stalls while idling is on.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected %0d got %0d", results_seen, what, want, got);
    endfunction

    // Every accepted result against the oldest owed one, field by field.
    always @(posedge clk) begin : check_results
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[4:0]);
            if (expected_levels.size() == 0) begin
                note_mismatch("result with nothing owed, tdata", 0, m_tdata);
            end else begin
                want = expected_levels.pop_front();
                if (got.d0 !== want.d0) note_mismatch("data0", want.d0, got.d0);
                if (got.d1 !== want.d1) note_mismatch("data1", want.d1, got.d1);
                if (got.busy !== want.busy) note_mismatch("busy", want.busy, got.busy);
                if (got.done !== want.done) note_mismatch("done", want.done, got.done);
                if (got.rej !== want.rej) note_mismatch("rejected", want.rej, got.rej);
                if (m_tdata[M_TDATA_W-1:5] !== '0)
                    note_mismatch("pad bits", 0, m_tdata[M_TDATA_W-1:5]);
            end
            results_seen++;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("wiegand_frame_transmitter_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset timing (pulse 1, gap 18), ticks while idle, a start while busy.
    task automatic test_reset_timing();
        repeat (3) send_tick();
        send_request(OP_START, 64'h1, 7'd2, 1'b0, 1'b0);
        send_tick();
        send_random_start();
        run_out_frame(0);
        send_tick();
    endtask

    // Zero timing values act as one; shortest frames, empty, parity-only,
    // full and oversized counts, both orders.
    task automatic test_edge_frames();
        write_timing(REG_PULSE, '0);
        write_timing(REG_GAP, '0);
        send_frame({$urandom, $urandom}, 7'd0, 1'b1, 1'b0, 0);   // empty: done on the start
        send_tick();
        send_frame({$urandom, $urandom}, 7'd0, 1'b1, 1'b1, 0);   // parity bits only
        send_frame({$urandom, $urandom}, 7'd0, 1'b0, 1'b1, 0);
        send_frame('1, 7'd64, 1'b1, 1'b1, 0);
        send_frame('0, 7'd64, 1'b0, 1'b1, 0);
        send_frame({$urandom, $urandom}, 7'd127, 1'b0, 1'b1, 0); // saturates to 64
        send_frame({$urandom, $urandom}, 7'd65, 1'b1, 1'b0, 0);
        send_frame(64'h1, 7'd1, 1'b1, 1'b0, 0);
        send_frame(64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 1'b1, 1'b0, 0);
        send_frame({$urandom, $urandom}, 7'd9, 1'b0, 1'b1, 0);
        // start refused mid-frame, state kept
        send_request(OP_START, 64'h5A, 7'd8, 1'b1, 1'b1);
        send_tick();
        send_request(OP_START, '1, 7'd64, 1'b0, 1'b0);
        run_out_frame(0);
    endtask

    // Largest pulse and gap, left part way and cut short by a lower setting;
    // a pulse write with bits above the register width.
    task automatic test_timing_extremes();
        write_timing(REG_PULSE, 20'h0FFFF);
        write_timing(REG_GAP, 20'hFFFFF);
        send_request(OP_START, 64'h2, 7'd2, 1'b1, 1'b0);
        repeat (8) send_tick();
        write_timing(REG_PULSE, 20'h00001);
        repeat (8) send_tick();
        write_timing(REG_GAP, 20'h00002);
        write_timing(REG_PULSE, 20'hF0003);                       // upper bits dropped
        run_out_frame(5);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming:
    // queue fills and the input stalls.
    task automatic test_backpressure();
        write_timing(REG_PULSE, 20'd2);
        write_timing(REG_GAP, 20'd3);
        hold_asks <= hold_asks + 1;
        send_frame({$urandom, $urandom}, 7'd16, 1'b1, 1'b1, 2);
    endtask

    // Mostly whole frames with random content, some loose ticks and stray starts.
    task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] pulse_value,
                                       input logic [CFG_DATA_W-1:0] gap_value,
                                       input int unsigned request_budget);
        int unsigned stop_at;
        write_timing(REG_PULSE, pulse_value);
        write_timing(REG_GAP, gap_value);
        stop_at = requests_sent + request_budget;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                send_frame({$urandom, $urandom}, pick_count(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 3);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 0) send_tick();
                    else send_random_start();
                end
            end
        end
    endtask

    initial begin
        reset_wiegand_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_edge_frames();
        test_timing_extremes();
        test_backpressure();
        test_random_traffic(20'd1, 20'd1, 70);
        test_random_traffic(20'd0, 20'd2, 70);
        test_random_traffic(20'd3, 20'd4, 60);
        // final stretch runs flat out on both sides
        idling_on <= 1'b0;
        test_random_traffic(20'd2, 20'd1, 90);
        wait_drained();

        if (mismatches == 0) begin
            $display("wiegand_frame_transmitter_top: match");
        end else begin
            $display("wiegand_frame_transmitter_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wft_pkg.sv
hw/rtl/wft_front.sv
hw/rtl/wft_fifo.sv
hw/rtl/wft_back.sv
hw/rtl/wiegand_frame_transmitter_top.sv
tb/tb_wiegand_frame_transmitter_top.sv
